// File: hw/rtl/top_k_hit_count_keeper_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the top-k hit count keeper
// Clocked implication checks with an asynchronous active-low reset.
// ----------------------------------------------------------------------------
`ifndef TOP_K_HIT_COUNT_KEEPER_ASSERT_SVH
`define TOP_K_HIT_COUNT_KEEPER_ASSERT_SVH

// Same-cycle implication
`define TKH_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tkh check failed");

// Next-cycle implication
`define TKH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tkh check failed");

`endif

// File: hw/rtl/tkh_pkg.sv
// ----------------------------------------------------------------------------
// tkh_pkg
// Shared widths, command codes and controller/datapath interface structs.
// ----------------------------------------------------------------------------
package tkh_pkg;

    localparam int TABLE_ENTRIES = 10;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int CMD_W         = 2;
    localparam int REC_W         = 16;
    localparam int CNT_W         = 10;
    localparam int RANK_W        = 5;

    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_OFFER  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REPORT = 2'd2;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;
        logic clear;
        logic scan_step;
        logic commit;
        logic sort_step;
        logic emit_step;
    } tkh_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic scan_done;
        logic sort_done;
        logic emit_done;
    } tkh_stat_t;

endpackage

// File: hw/rtl/tkh_ctrl.sv
// ----------------------------------------------------------------------------
// tkh_ctrl
// Sequencer for clear, offer scan/commit and report sort/emit.
// ----------------------------------------------------------------------------
`include "top_k_hit_count_keeper_assert.svh"

module tkh_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [tkh_pkg::CMD_W-1:0] command,
    input  tkh_pkg::tkh_stat_t      stat,
    output tkh_pkg::tkh_cmd_t       cmd,
    output logic                    busy
);
    import tkh_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SCAN  = 3'd1;
    localparam logic [2:0] ST_WRITE = 3'd2;
    localparam logic [2:0] ST_SORT  = 3'd3;
    localparam logic [2:0] ST_EMIT  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       accept;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;

    // Decode state into datapath commands and next state
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.load = 1'b1;
                    priority if (command == CMD_CLEAR)
                    begin
                        cmd.clear = 1'b1;
                    end
                    else if (command == CMD_OFFER)
                    begin
                        state_next = ST_SCAN;
                    end
                    else if (command == CMD_REPORT)
                    begin
                        state_next = ST_SORT;
                    end
                    else
                    begin
                        // Drop the unused code, stay idle
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.scan_done)
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                cmd.commit = 1'b1;
                state_next = ST_IDLE;
            end
            ST_SORT:
            begin
                cmd.sort_step = 1'b1;
                if (stat.sort_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                cmd.emit_step = 1'b1;
                if (stat.emit_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `TKH_ASSERT_NEXT(a_commit_idle, clk, rst_n, cmd.commit, !busy)
    `TKH_ASSERT_NEXT(a_sort_to_emit, clk, rst_n, cmd.sort_step && stat.sort_done,
        cmd.emit_step)
    `TKH_ASSERT_NOW(a_one_step, clk, rst_n, 1'b1,
        $onehot0({cmd.scan_step, cmd.commit, cmd.sort_step, cmd.emit_step, cmd.load}))

endmodule

// File: hw/rtl/tkh_datapath.sv
// ----------------------------------------------------------------------------
// tkh_datapath
// Slot table, minimum scan, odd-even transposition sort and result registers.
// ----------------------------------------------------------------------------
`include "top_k_hit_count_keeper_assert.svh"

module tkh_datapath (
    input  logic                       clk,
    input  logic                       rst_n,
    input  tkh_pkg::tkh_cmd_t          cmd,
    input  logic [tkh_pkg::REC_W-1:0]  record_id,
    input  logic [tkh_pkg::CNT_W-1:0]  hit_count,
    output tkh_pkg::tkh_stat_t         stat,
    output logic                       strobe,
    output logic [tkh_pkg::RANK_W-1:0] rank,
    output logic [tkh_pkg::REC_W-1:0]  out_record,
    output logic [tkh_pkg::CNT_W-1:0]  out_count,
    output logic                       empty_res,
    output logic                       last
);
    import tkh_pkg::*;

    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_ENTRIES - 1);

    logic [CNT_W-1:0]         cnt_reg [TABLE_ENTRIES];
    logic [CNT_W-1:0]         cnt_next [TABLE_ENTRIES];
    logic [REC_W-1:0]         rec_reg [TABLE_ENTRIES];
    logic [REC_W-1:0]         rec_next [TABLE_ENTRIES];
    logic [IDX_W-1:0]         idx_reg;
    logic [IDX_W-1:0]         best_idx_reg;
    logic [CNT_W-1:0]         best_cnt_reg;
    logic [REC_W-1:0]         in_rec_reg;
    logic [CNT_W-1:0]         in_cnt_reg;
    logic [TABLE_ENTRIES-1:0] nz;
    logic [TABLE_ENTRIES-1:0] nz_above;
    logic                     tbl_empty;
    logic                     emit_last;
    logic                     strobe_reg;
    logic [RANK_W-1:0]        rank_reg;
    logic [REC_W-1:0]         out_record_reg;
    logic [CNT_W-1:0]         out_count_reg;
    logic                     empty_reg;
    logic                     last_reg;

    // Flag nonzero slots; after the sort they form a prefix
    always_comb
    begin
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            nz[i] = (cnt_reg[i] != '0);
        end
    end

    assign nz_above  = nz >> 1;
    assign tbl_empty = !nz[0];
    assign emit_last = tbl_empty || (idx_reg == IDX_LAST) || !nz_above[idx_reg];

    assign stat.scan_done = (idx_reg == IDX_LAST);
    assign stat.sort_done = (idx_reg == IDX_LAST);
    assign stat.emit_done = emit_last;

    // Build next table: clear, commit the offer, or one sort round
    always_comb
    begin
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            cnt_next[i] = cnt_reg[i];
            rec_next[i] = rec_reg[i];
        end
        priority if (cmd.clear)
        begin
            for (int i = 0; i < TABLE_ENTRIES; i++)
            begin
                cnt_next[i] = '0;
                rec_next[i] = '0;
            end
        end
        else if (cmd.commit)
        begin
            if (best_cnt_reg <= in_cnt_reg)
            begin
                cnt_next[best_idx_reg] = in_cnt_reg;
                rec_next[best_idx_reg] = in_rec_reg;
            end
        end
        else if (cmd.sort_step)
        begin
            // Swap disjoint neighbor pairs of the current parity on strictly less
            for (int j = 0; j < TABLE_ENTRIES - 1; j++)
            begin
                if ((idx_reg[0] == 1'(j % 2)) && (cnt_reg[j] < cnt_reg[j+1]))
                begin
                    cnt_next[j]   = cnt_reg[j+1];
                    rec_next[j]   = rec_reg[j+1];
                    cnt_next[j+1] = cnt_reg[j];
                    rec_next[j+1] = rec_reg[j];
                end
            end
        end
        else
        begin
            // Hold every slot
            for (int i = 0; i < TABLE_ENTRIES; i++)
            begin
                cnt_next[i] = cnt_reg[i];
                rec_next[i] = rec_reg[i];
            end
        end
    end

    // Hold the slot table
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TABLE_ENTRIES; i++)
            begin
                cnt_reg[i] <= '0;
                rec_reg[i] <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < TABLE_ENTRIES; i++)
            begin
                cnt_reg[i] <= cnt_next[i];
                rec_reg[i] <= rec_next[i];
            end
        end
    end

    // Advance the slot index and track the first minimum
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
        end
        else if (cmd.load)
        begin
            idx_reg <= '0;
        end
        else if (cmd.scan_step || cmd.emit_step)
        begin
            idx_reg <= idx_reg + 1'b1;
        end
        else if (cmd.sort_step)
        begin
            idx_reg <= (idx_reg == IDX_LAST) ? '0 : idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            in_rec_reg   <= record_id;
            in_cnt_reg   <= hit_count;
            best_idx_reg <= '0;
            best_cnt_reg <= cnt_reg[0];
        end
        else if (cmd.scan_step && (cnt_reg[idx_reg] < best_cnt_reg))
        begin
            best_idx_reg <= idx_reg;
            best_cnt_reg <= cnt_reg[idx_reg];
        end
    end

    // Register one result beat per emit step
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= cmd.emit_step;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_step)
        begin
            rank_reg       <= RANK_W'(idx_reg);
            out_record_reg <= tbl_empty ? '0 : rec_reg[idx_reg];
            out_count_reg  <= tbl_empty ? '0 : cnt_reg[idx_reg];
            empty_reg      <= tbl_empty;
            last_reg       <= emit_last;
        end
    end

    assign strobe     = strobe_reg;
    assign rank       = rank_reg;
    assign out_record = out_record_reg;
    assign out_count  = out_count_reg;
    assign empty_res  = empty_reg;
    assign last       = last_reg;

    `TKH_ASSERT_NOW(a_empty_is_last, clk, rst_n, strobe && empty_res, last && (rank == '0))
    `TKH_ASSERT_NOW(a_beat_positive, clk, rst_n, strobe && !empty_res, out_count != '0)
    `TKH_ASSERT_NEXT(a_beat_follows_emit, clk, rst_n, cmd.emit_step, strobe)

endmodule

// File: hw/rtl/top_k_hit_count_keeper.sv
// ----------------------------------------------------------------------------
// top_k_hit_count_keeper
// Keeps the best scored records in a small slot table; clear, offer, report.
// ----------------------------------------------------------------------------
//  channel   handshake          payload
//  command   start / busy       command, record_id, hit_count
//  result    strobe (1 cycle)   rank, out_record, out_count, empty_res, last
//
//  Clear and unused codes are done in the cycle that accepts them; an offer
//  runs the one-slot-per-cycle minimum scan over the table, then the write.
//  A report runs TABLE_ENTRIES sort rounds, then issues one result beat per cycle
//  (1 to TABLE_ENTRIES beats); busy stays high until the last beat issues.
//  Reset clears the table and the sequencer. The receiver cannot stall:
//  each beat is valid for exactly one cycle.
// ----------------------------------------------------------------------------
module top_k_hit_count_keeper (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [tkh_pkg::CMD_W-1:0]  command,
    input  logic [tkh_pkg::REC_W-1:0]  record_id,
    input  logic [tkh_pkg::CNT_W-1:0]  hit_count,
    output logic                       strobe,
    output logic [tkh_pkg::RANK_W-1:0] rank,
    output logic [tkh_pkg::REC_W-1:0]  out_record,
    output logic [tkh_pkg::CNT_W-1:0]  out_count,
    output logic                       empty_res,
    output logic                       last
);
    import tkh_pkg::*;

    tkh_cmd_t  cmd;
    tkh_stat_t stat;

    tkh_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .command (command),
        .stat    (stat),
        .cmd     (cmd),
        .busy    (busy)
    );

    tkh_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .record_id  (record_id),
        .hit_count  (hit_count),
        .stat       (stat),
        .strobe     (strobe),
        .rank       (rank),
        .out_record (out_record),
        .out_count  (out_count),
        .empty_res  (empty_res),
        .last       (last)
    );

endmodule

// File: tb/top_k_hit_count_keeper_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// top_k_hit_count_keeper_checker
// Watches the command and result channels of the top-k keeper. It keeps its
// own copy of the slot table, predicts the ranked beats of every accepted
// report and compares each result beat with the oldest prediction.
// ----------------------------------------------------------------------------
module top_k_hit_count_keeper_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic                       busy,
    input  logic [tkh_pkg::CMD_W-1:0]  command,
    input  logic [tkh_pkg::REC_W-1:0]  record_id,
    input  logic [tkh_pkg::CNT_W-1:0]  hit_count,
    input  logic                       strobe,
    input  logic [tkh_pkg::RANK_W-1:0] rank,
    input  logic [tkh_pkg::REC_W-1:0]  out_record,
    input  logic [tkh_pkg::CNT_W-1:0]  out_count,
    input  logic                       empty_res,
    input  logic                       last,
    output int                         fails,
    output int                         pending,
    output int                         reports_seen,
    output int                         empty_seen,
    output int                         beats_seen
);

    localparam int ENTRIES = tkh_pkg::TABLE_ENTRIES;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [tkh_pkg::RANK_W-1:0] rank;
        logic [tkh_pkg::REC_W-1:0]  rec;
        logic [tkh_pkg::CNT_W-1:0]  cnt;
        logic                       empty;
        logic                       last;
    } ranked_beat_t;

    logic [tkh_pkg::CNT_W-1:0] kept_count  [ENTRIES];
    logic [tkh_pkg::REC_W-1:0] kept_record [ENTRIES];
    ranked_beat_t              due_beats   [$];

    // Zero every slot
    task automatic keep_clear();
        for (int i = 0; i < ENTRIES; i++)
        begin
            kept_count[i]  = '0;
            kept_record[i] = '0;
        end
    endtask

    // Overwrite the first lowest slot when the offer reaches its count
    task automatic keep_offer(input logic [tkh_pkg::REC_W-1:0] rec,
                              input logic [tkh_pkg::CNT_W-1:0] cnt);
        int low_slot;
        low_slot = 0;
        for (int i = 1; i < ENTRIES; i++)
        begin
            if (kept_count[i] < kept_count[low_slot])
                low_slot = i;
        end
        if (kept_count[low_slot] <= cnt)
        begin
            kept_count[low_slot]  = cnt;
            kept_record[low_slot] = rec;
        end
    endtask

    // Sort in place, then queue one beat per positive slot, or one empty beat if none
    task automatic keep_report();
        logic [tkh_pkg::CNT_W-1:0] tmp_cnt;
        logic [tkh_pkg::REC_W-1:0] tmp_rec;
        ranked_beat_t              beat;
        int                        positive;
        int                        n;
        for (int pass = 0; pass < ENTRIES; pass++)
        begin
            for (int j = 0; j + 1 < ENTRIES; j++)
            begin
                if (kept_count[j] < kept_count[j+1])
                begin
                    tmp_cnt          = kept_count[j];
                    tmp_rec          = kept_record[j];
                    kept_count[j]    = kept_count[j+1];
                    kept_record[j]   = kept_record[j+1];
                    kept_count[j+1]  = tmp_cnt;
                    kept_record[j+1] = tmp_rec;
                end
            end
        end
        positive = 0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (kept_count[i] != '0)
                positive++;
        end
        reports_seen++;
        if (positive == 0)
        begin
            beat.rank  = '0;
            beat.rec   = '0;
            beat.cnt   = '0;
            beat.empty = 1'b1;
            beat.last  = 1'b1;
            due_beats.push_back(beat);
            empty_seen++;
        end
        else
        begin
            n = 0;
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (kept_count[i] != '0)
                begin
                    beat.rank  = n[tkh_pkg::RANK_W-1:0];
                    beat.rec   = kept_record[i];
                    beat.cnt   = kept_count[i];
                    beat.empty = 1'b0;
                    beat.last  = (n + 1 == positive);
                    due_beats.push_back(beat);
                    n++;
                end
            end
        end
    endtask

    // Compare one result beat with the oldest prediction
    task automatic check_beat();
        ranked_beat_t want;
        beats_seen++;
        if (due_beats.size() == 0)
        begin
            fails++;
            if (fails <= REPORT_LIMIT)
                $display("%0t: unexpected beat rank %0d rec %h cnt %0d empty %b last %b",
                         $realtime, rank, out_record, out_count, empty_res, last);
        end
        else
        begin
            want = due_beats.pop_front();
            if (want.rank != rank || want.rec != out_record || want.cnt != out_count ||
                want.empty != empty_res || want.last != last)
            begin
                fails++;
                if (fails <= REPORT_LIMIT)
                begin
                    $display("%0t: beat mismatch", $realtime);
                    $display("  expected rank %0d rec %h cnt %0d empty %b last %b",
                             want.rank, want.rec, want.cnt, want.empty, want.last);
                    $display("  actual   rank %0d rec %h cnt %0d empty %b last %b",
                             rank, out_record, out_count, empty_res, last);
                end
            end
        end
    endtask

    // Track both channels on every edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keep_clear();
            due_beats.delete();
            pending      <= 0;
            fails        = 0;
            reports_seen = 0;
            empty_seen   = 0;
            beats_seen   = 0;
        end
        else
        begin
            if (strobe)
                check_beat();
            if (start && !busy)
            begin
                case (command)
                    tkh_pkg::CMD_CLEAR:  keep_clear();
                    tkh_pkg::CMD_OFFER:  keep_offer(record_id, hit_count);
                    tkh_pkg::CMD_REPORT: keep_report();
                    default:             ;
                endcase
            end
            pending <= due_beats.size();
        end
    end

endmodule

// File: tb/top_k_hit_count_keeper_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// top_k_hit_count_keeper_tb
// Drives clear, offer and report commands into the top-k keeper: a directed
// opening on extremes, ties, overflow of the table and empty reports, then
// random command streams with random gaps. The checker judges every beat.
// ----------------------------------------------------------------------------
module top_k_hit_count_keeper_tb;

    localparam logic [tkh_pkg::CMD_W-1:0] CMD_SPARE = 2'd3;
    localparam int RANDOM_ITEMS = 185;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int SETTLE       = 40;

    logic                       clk       = 1'b0;
    logic                       rst_n     = 1'b0;
    logic                       start     = 1'b0;
    logic [tkh_pkg::CMD_W-1:0]  command   = '0;
    logic [tkh_pkg::REC_W-1:0]  record_id = '0;
    logic [tkh_pkg::CNT_W-1:0]  hit_count = '0;
    logic                       busy;
    logic                       strobe;
    logic [tkh_pkg::RANK_W-1:0] rank;
    logic [tkh_pkg::REC_W-1:0]  out_record;
    logic [tkh_pkg::CNT_W-1:0]  out_count;
    logic                       empty_res;
    logic                       last;

    int fails;
    int pending;
    int reports_seen;
    int empty_seen;
    int beats_seen;
    int cycles = 0;
    int issued = 0;
    int counted;
    int roll;
    bit burst;

    logic [tkh_pkg::CNT_W-1:0] table_fill [12] =
        '{10'd3, 10'd7, 10'd7, 10'd1023, 10'd0, 10'd512,
          10'd7, 10'd3, 10'd3, 10'd1, 10'd1000, 10'd7};

    top_k_hit_count_keeper uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .command    (command),
        .record_id  (record_id),
        .hit_count  (hit_count),
        .strobe     (strobe),
        .rank       (rank),
        .out_record (out_record),
        .out_count  (out_count),
        .empty_res  (empty_res),
        .last       (last)
    );

    top_k_hit_count_keeper_checker watch (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .command      (command),
        .record_id    (record_id),
        .hit_count    (hit_count),
        .strobe       (strobe),
        .rank         (rank),
        .out_record   (out_record),
        .out_count    (out_count),
        .empty_res    (empty_res),
        .last         (last),
        .fails        (fails),
        .pending      (pending),
        .reports_seen (reports_seen),
        .empty_seen   (empty_seen),
        .beats_seen   (beats_seen)
    );

    always #5 clk = ~clk;

    // Bound the run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Hold one command beat until the block takes it
    task automatic issue(input logic [tkh_pkg::CMD_W-1:0] cmd,
                         input logic [tkh_pkg::REC_W-1:0] rec,
                         input logic [tkh_pkg::CNT_W-1:0] cnt);
        start     <= 1'b1;
        command   <= cmd;
        record_id <= rec;
        hit_count <= cnt;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        issued++;
    endtask

    // Drop start for a number of cycles
    task automatic idle_for(input int n);
        if (n > 0)
        begin
            start <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // Hold off until every predicted beat has arrived
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (busy || pending != 0)
            @(posedge clk);
    endtask

    function automatic int pick_gap(input bit no_idle);
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic logic [tkh_pkg::REC_W-1:0] any_rec();
        return tkh_pkg::REC_W'($urandom_range(0, 65535));
    endfunction

    function automatic logic [tkh_pkg::CNT_W-1:0] any_cnt();
        return tkh_pkg::CNT_W'($urandom_range(0, 1023));
    endfunction

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Report straight after reset, then a zero offer that stays hidden
        issue(tkh_pkg::CMD_REPORT, any_rec(), any_cnt());
        idle_for(pick_gap(1'b0));
        issue(tkh_pkg::CMD_OFFER, 16'hFFFF, 10'd0);
        issue(tkh_pkg::CMD_REPORT, 16'h0000, 10'd0);
        idle_for(pick_gap(1'b0));

        // Extremes and a tie on the minimum
        issue(tkh_pkg::CMD_OFFER, 16'h0000, 10'd1023);
        issue(tkh_pkg::CMD_OFFER, 16'h1234, 10'd1);
        issue(tkh_pkg::CMD_OFFER, 16'hABCD, 10'd1);
        issue(CMD_SPARE, 16'hFFFF, 10'h3FF);
        issue(tkh_pkg::CMD_REPORT, 16'hFFFF, 10'h3FF);
        drain();

        // Overfill the table with ties and zeros
        for (int i = 0; i < 12; i++)
        begin
            idle_for(pick_gap(1'b0));
            issue(tkh_pkg::CMD_OFFER, 16'h8000 + i[15:0], table_fill[i]);
        end
        issue(tkh_pkg::CMD_REPORT, any_rec(), any_cnt());
        // Offer against the sorted layout
        issue(tkh_pkg::CMD_OFFER, 16'h5A5A, 10'd500);
        issue(tkh_pkg::CMD_REPORT, any_rec(), any_cnt());
        issue(tkh_pkg::CMD_CLEAR, 16'hFFFF, 10'h3FF);
        issue(tkh_pkg::CMD_REPORT, any_rec(), any_cnt());
        drain();

        // Random command streams, mostly offers with occasional reports
        counted = 0;
        burst = 1'b0;
        while (counted < RANDOM_ITEMS)
        begin
            if (counted % 40 == 0)
                burst = ($urandom_range(0, 2) == 0);
            idle_for(pick_gap(burst));
            roll = $urandom_range(0, 99);
            if (roll < 6)
            begin
                issue(tkh_pkg::CMD_CLEAR, any_rec(), any_cnt());
                counted++;
            end
            else if (roll < 10)
            begin
                issue(CMD_SPARE, any_rec(), any_cnt());
            end
            else if (roll < 24)
            begin
                issue(tkh_pkg::CMD_REPORT, any_rec(), any_cnt());
                counted++;
                if ($urandom_range(0, 3) == 0)
                    drain();
            end
            else
            begin
                if ($urandom_range(0, 1) == 0)
                    issue(tkh_pkg::CMD_OFFER, any_rec(),
                          tkh_pkg::CNT_W'($urandom_range(0, 15)));
                else
                    issue(tkh_pkg::CMD_OFFER, any_rec(), any_cnt());
                counted++;
            end
        end
        issue(tkh_pkg::CMD_REPORT, any_rec(), any_cnt());

        // Wait out the tail
        drain();
        repeat (SETTLE) @(posedge clk);

        $display("Sent %0d commands; %0d reports, %0d of them empty, %0d beats compared",
                 issued, reports_seen, empty_seen, beats_seen);
        if (fails == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
